// ===== rtl/i2cs_pkg.sv =====
// Shared types and constants for the I2C register sequencer.
// Covers the item kind codes, the phase codes, the buffer sizing and the
// transaction and result structs. Has no dependencies.
package i2cs_pkg;

   // write buffer sizing
   localparam int BUF_DEPTH = 32;
   localparam int PTR_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);

   // fixed field widths
   localparam int KIND_W  = 3;
   localparam int SADDR_W = 7;
   localparam int BYTE_W  = 8;
   localparam int REQCNT_W = 6;
   localparam int RXIDX_W = 5;

   // input item kinds
   localparam logic [KIND_W-1:0] KIND_LOAD        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_START_READ  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_START_WRITE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_TX_READY    = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RX_BYTE     = 3'd4;

   // sequencer phases
   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SEND_REG = 3'd1,
      PH_SWITCH   = 3'd2,
      PH_TX_DATA  = 3'd3,
      PH_RX_DATA  = 3'd4
   } phase_type;

   // one input transaction
   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [SADDR_W-1:0]  slave_addr;
      logic [BYTE_W-1:0]   reg_sel;
      logic [REQCNT_W-1:0] count;
      logic [BYTE_W-1:0]   data_byte;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic                start_tx;
      logic                restart_rx;
      logic                send_stop;
      logic                tx_valid;
      logic [BYTE_W-1:0]   tx_byte;
      logic [SADDR_W-1:0]  target_addr;
      logic                rx_valid;
      logic [RXIDX_W-1:0]  rx_index;
      logic [BYTE_W-1:0]   rx_data;
      logic                done_res;
      logic [2:0]          phase;
   } result_type;

   // write port of the byte store
   typedef struct packed {
      logic              en;
      logic [PTR_W-1:0]  addr;
      logic [BYTE_W-1:0] data;
   } store_wr_type;

   // limit a requested byte count to the buffer depth
   function automatic logic [CNT_W-1:0] clamp_count(input logic [REQCNT_W-1:0] cnt);
      logic [CNT_W-1:0] lim;
      lim = CNT_W'(BUF_DEPTH);
      if (CNT_W'(cnt) > lim || (REQCNT_W > CNT_W && (cnt >> CNT_W) != '0)) begin
         return lim;
      end
      return CNT_W'(cnt);
   endfunction

endpackage

// ===== rtl/i2cs_wstore.sv =====
// Write byte store: one write port, one registered read port.
// A write to the address being read in the same cycle is forwarded.
// Depends on i2cs_pkg.
module i2cs_wstore
   import i2cs_pkg::*;
(
   input  logic              clock,
   input  store_wr_type      wr,
   input  logic [PTR_W-1:0]  raddr,
   output logic [BYTE_W-1:0] rdata
);

   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;

   // storage write
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // registered read with write-through forwarding
   always_ff @(posedge clock) begin
      if (wr.en && wr.addr == raddr) begin
         rdata_ff <= wr.data;
      end else begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/i2cs_engine.sv =====
// Sequencer state and per-transaction next-state / result logic.
// Drives the byte store write port and prefetch address.
// Depends on i2cs_pkg.
module i2cs_engine
   import i2cs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  item_type          item,
   input  logic [BYTE_W-1:0] store_rdata,
   output store_wr_type      store_wr,
   output logic [PTR_W-1:0]  store_raddr,
   output result_type        result
);

   phase_type            phase_ff, phase_in;
   logic [BYTE_W-1:0]    reg_sel_ff, reg_sel_in;
   logic [SADDR_W-1:0]   slave_ff, slave_in;
   logic [CNT_W-1:0]     rx_rem_ff, rx_rem_in;
   logic [CNT_W-1:0]     tx_rem_ff, tx_rem_in;
   logic [RXIDX_W-1:0]   rx_pos_ff, rx_pos_in;
   logic [CNT_W-1:0]     tx_pos_ff, tx_pos_in;
   logic [CNT_W-1:0]     load_pos_ff, load_pos_in;

   // next state and result for the transaction in hand
   always_comb begin
      phase_in    = phase_ff;
      reg_sel_in  = reg_sel_ff;
      slave_in    = slave_ff;
      rx_rem_in   = rx_rem_ff;
      tx_rem_in   = tx_rem_ff;
      rx_pos_in   = rx_pos_ff;
      tx_pos_in   = tx_pos_ff;
      load_pos_in = load_pos_ff;
      store_wr    = '0;
      result      = '0;

      if (en) begin
         unique case (item.kind)
            KIND_LOAD: begin
               if (load_pos_ff < CNT_W'(BUF_DEPTH)) begin
                  store_wr.en   = 1'b1;
                  store_wr.addr = load_pos_ff[PTR_W-1:0];
                  store_wr.data = item.data_byte;
                  load_pos_in   = load_pos_ff + 1'b1;
               end
            end
            KIND_START_READ, KIND_START_WRITE: begin
               // open a transaction, aborting any in progress
               phase_in    = PH_SEND_REG;
               reg_sel_in  = item.reg_sel;
               slave_in    = item.slave_addr;
               rx_pos_in   = '0;
               tx_pos_in   = '0;
               if (item.kind == KIND_START_READ) begin
                  rx_rem_in = clamp_count(item.count);
                  tx_rem_in = '0;
               end else begin
                  tx_rem_in   = clamp_count(item.count);
                  rx_rem_in   = '0;
                  load_pos_in = '0;
               end
               result.start_tx    = 1'b1;
               result.target_addr = item.slave_addr;
            end
            KIND_TX_READY: begin
               unique case (phase_ff)
                  PH_SEND_REG: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = reg_sel_ff;
                     phase_in = (rx_rem_ff != '0) ? PH_SWITCH : PH_TX_DATA;
                  end
                  PH_SWITCH: begin
                     result.restart_rx  = 1'b1;
                     result.target_addr = slave_ff;
                     result.send_stop   = (rx_rem_ff == CNT_W'(1));
                     phase_in           = PH_RX_DATA;
                  end
                  PH_TX_DATA: begin
                     if (tx_rem_ff != '0 && tx_pos_ff < CNT_W'(BUF_DEPTH)) begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = store_rdata;
                        tx_pos_in       = tx_pos_ff + 1'b1;
                        tx_rem_in       = tx_rem_ff - 1'b1;
                     end else begin
                        tx_rem_in        = '0;
                        result.send_stop = 1'b1;
                        result.done_res  = 1'b1;
                        phase_in         = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_RX_BYTE: begin
               if (phase_ff == PH_RX_DATA) begin
                  if (rx_rem_ff != '0) begin
                     result.rx_valid = 1'b1;
                     result.rx_index = rx_pos_ff;
                     result.rx_data  = item.data_byte;
                     rx_pos_in       = rx_pos_ff + 1'b1;
                     rx_rem_in       = rx_rem_ff - 1'b1;
                  end
                  // stop goes out with the second to last byte
                  if (rx_rem_in == CNT_W'(1)) begin
                     result.send_stop = 1'b1;
                  end else if (rx_rem_in == '0) begin
                     result.done_res = 1'b1;
                     phase_in        = PH_IDLE;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      result.phase = phase_in;
   end

   // prefetch the store entry for the next transmit byte
   assign store_raddr = tx_pos_in[PTR_W-1:0];

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         reg_sel_ff  <= '0;
         slave_ff    <= '0;
         rx_rem_ff   <= '0;
         tx_rem_ff   <= '0;
         rx_pos_ff   <= '0;
         tx_pos_ff   <= '0;
         load_pos_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         reg_sel_ff  <= reg_sel_in;
         slave_ff    <= slave_in;
         rx_rem_ff   <= rx_rem_in;
         tx_rem_ff   <= tx_rem_in;
         rx_pos_ff   <= rx_pos_in;
         tx_pos_ff   <= tx_pos_in;
         load_pos_ff <= load_pos_in;
      end
   end

endmodule

// ===== rtl/i2c_master_register_sequencer_top.sv =====
// Top level of the I2C register sequencer: input register, engine,
// byte store and result register with stream handshakes.
// Depends on i2cs_pkg, i2cs_engine and i2cs_wstore.
//
// Usage:
//   req_* carries one command or bus event per transaction: the kind in
//   req_tuser, the address, count and data fields in req_tdata.
//   rsp_* returns exactly one result per request, in order: start,
//   repeated start and stop requests, the next byte to transmit, a
//   received byte with its index, completion and the phase.
//   rsp_tvalid rises after request acceptance once the request has passed
//   the input register and then, through the sequencer logic, the result
//   register. Throughput is one transaction per cycle while rsp_tready
//   is high; the store read for the next transmit byte is prefetched
//   through the store's registered read port.
//   When rsp_tready is low with a result waiting, the result register and
//   the input register both hold, and req_tready drops once the input register is full.
//   Reset clears the phase, counters and positions; the write store is
//   not cleared and must be loaded before its bytes are sent.
module i2c_master_register_sequencer_top
   import i2cs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // slave_addr[6:0], reg_sel[14:7], count[20:15],
                                   // data_byte[28:21], zero pad
   input  logic [2:0]  req_tuser,  // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // start_tx[0], restart_rx[1], send_stop[2],
                                   // tx_valid[3], tx_byte[11:4], target_addr[18:12],
                                   // rx_valid[19], rx_index[24:20], rx_data[32:25],
                                   // done_res[33], phase[36:34], zero pad
);

   logic              in_valid_ff;
   item_type          in_item_ff;
   logic              out_valid_ff;
   result_type        out_res_ff;
   logic              advance;
   item_type          req_item;
   result_type        eng_res;
   store_wr_type      store_wr;
   logic [PTR_W-1:0]  store_raddr;
   logic [BYTE_W-1:0] store_rdata;

   // stage advances when the result register is free or being drained
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;

   // unpack request
   assign req_item.kind       = req_tuser;
   assign req_item.slave_addr = req_tdata[6:0];
   assign req_item.reg_sel    = req_tdata[14:7];
   assign req_item.count      = req_tdata[20:15];
   assign req_item.data_byte  = req_tdata[28:21];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_item;
      end
   end

   i2cs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .en          (in_valid_ff && advance),
      .item        (in_item_ff),
      .store_rdata (store_rdata),
      .store_wr    (store_wr),
      .store_raddr (store_raddr),
      .result      (eng_res)
   );

   i2cs_wstore u_wstore (
      .clock (clock),
      .wr    (store_wr),
      .raddr (store_raddr),
      .rdata (store_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         out_res_ff <= eng_res;
      end
   end

   // pack result
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.phase,
                        out_res_ff.done_res,
                        out_res_ff.rx_data,
                        out_res_ff.rx_index,
                        out_res_ff.rx_valid,
                        out_res_ff.target_addr,
                        out_res_ff.tx_byte,
                        out_res_ff.tx_valid,
                        out_res_ff.send_stop,
                        out_res_ff.restart_rx,
                        out_res_ff.start_tx};

endmodule

// ===== tb/i2c_master_register_sequencer_top_tb.sv =====
// Self-checking testbench for the I2C register read/write sequencer.
// Uses i2cs_pkg for the item, result and phase types; drives i2c_master_register_sequencer_top
// through its stream ports and checks every result against a cycle-free predictor.
`timescale 1ns / 100ps

module i2c_master_register_sequencer_top_tb;
   import i2cs_pkg::*;

   localparam int ITEMS_TOTAL = 1250;
   localparam int CALM_ITEMS  = 200;   // final stretch without idling

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // slave_addr[6:0], reg_sel[14:7], count[20:15], data_byte[28:21]
   logic [2:0]  req_tuser;   // kind[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // start_tx, restart_rx, send_stop, tx_valid, tx_byte, target_addr,
                             // rx_valid, rx_index, rx_data, done_res, phase (low bit first)

   // sequencer state as the predictor sees it
   phase_type         seq_ph;
   logic [BYTE_W-1:0] held_reg;
   logic [SADDR_W-1:0] held_slave;
   int                rx_left, tx_left, rx_pos, tx_pos, load_pos;
   logic [BYTE_W-1:0] store_bytes [BUF_DEPTH];
   int                store_filled;   // store entries 0..store_filled-1 hold loaded bytes

   result_type pending_results [$];
   int  mismatch_count;
   int  sent_count;
   bit  idle_on;
   int  hold_cycles;
   int  stall_left;

   i2c_master_register_sequencer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // byte count of a start command, limited to the store depth
   function automatic int count_limit(input logic [REQCNT_W-1:0] cnt);
      return (cnt > BUF_DEPTH) ? BUF_DEPTH : int'(cnt);
   endfunction

   // advance the sequencer state by one transaction and return its result
   function automatic result_type predict_sequencer(input item_type it);
      result_type r;
      r = '0;
      case (it.kind)
         KIND_LOAD: begin
            if (load_pos < BUF_DEPTH) begin
               store_bytes[load_pos] = it.data_byte;
               load_pos++;
               if (load_pos > store_filled) store_filled = load_pos;
            end
         end
         KIND_START_READ, KIND_START_WRITE: begin
            // a start always opens a fresh transaction, aborting any other
            seq_ph     = PH_SEND_REG;
            held_reg   = it.reg_sel;
            held_slave = it.slave_addr;
            rx_pos     = 0;
            tx_pos     = 0;
            if (it.kind == KIND_START_READ) begin
               rx_left = count_limit(it.count);
               tx_left = 0;
            end else begin
               tx_left  = count_limit(it.count);
               rx_left  = 0;
               load_pos = 0;
            end
            r.start_tx    = 1'b1;
            r.target_addr = held_slave;
         end
         KIND_TX_READY: begin
            case (seq_ph)
               PH_SEND_REG: begin
                  r.tx_valid = 1'b1;
                  r.tx_byte  = held_reg;
                  seq_ph     = (rx_left != 0) ? PH_SWITCH : PH_TX_DATA;
               end
               PH_SWITCH: begin
                  r.restart_rx  = 1'b1;
                  r.target_addr = held_slave;
                  seq_ph        = PH_RX_DATA;
                  if (rx_left == 1) r.send_stop = 1'b1;
               end
               PH_TX_DATA: begin
                  if (tx_left != 0 && tx_pos < BUF_DEPTH) begin
                     r.tx_valid = 1'b1;
                     r.tx_byte  = store_bytes[tx_pos];
                     tx_pos++;
                     tx_left--;
                  end else begin
                     tx_left    = 0;
                     r.send_stop = 1'b1;
                     r.done_res = 1'b1;
                     seq_ph     = PH_IDLE;
                  end
               end
               default: ;   // idle or receiving: nothing to send
            endcase
         end
         KIND_RX_BYTE: begin
            if (seq_ph == PH_RX_DATA) begin
               if (rx_left != 0) begin
                  r.rx_valid = 1'b1;
                  r.rx_index = RXIDX_W'(rx_pos);
                  r.rx_data  = it.data_byte;
                  rx_pos     = (rx_pos + 1) % 32;
                  rx_left--;
               end
               if (rx_left == 1) begin
                  r.send_stop = 1'b1;
               end else if (rx_left == 0) begin
                  r.done_res = 1'b1;
                  seq_ph     = PH_IDLE;
               end
            end
         end
         default: ;   // unused kinds leave everything alone
      endcase
      r.phase = seq_ph;
      return r;
   endfunction

   function automatic item_type build_item(input logic [KIND_W-1:0] kind,
                                           input logic [SADDR_W-1:0] slave,
                                           input logic [BYTE_W-1:0] regad,
                                           input logic [REQCNT_W-1:0] cnt,
                                           input logic [BYTE_W-1:0] data);
      item_type it;
      it.kind       = kind;
      it.slave_addr = slave;
      it.reg_sel    = regad;
      it.count      = cnt;
      it.data_byte  = data;
      return it;
   endfunction

   function automatic item_type random_item(input logic [KIND_W-1:0] kind);
      return build_item(kind, SADDR_W'($urandom), BYTE_W'($urandom),
                        REQCNT_W'($urandom), BYTE_W'($urandom));
   endfunction

   // offer one request transaction, wait for acceptance, record the expected result
   task automatic send_item(input item_type item_in);
      item_type it;
      int gap;
      it = item_in;
      // never send store entries that were not loaded since reset
      if (it.kind == KIND_START_WRITE && count_limit(it.count) > store_filled)
         it.count = REQCNT_W'(store_filled);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 10);
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {3'b000, it.data_byte, it.count, it.reg_sel, it.slave_addr};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_sequencer(it));
      sent_count++;
   endtask

   // step the open transaction to idle with the events its phase expects
   task automatic finish_transaction(input int noise_pct);
      int guard;
      guard = 0;
      while (seq_ph != PH_IDLE && guard < 80) begin
         if ($urandom_range(1, 100) <= noise_pct) begin
            if ($urandom_range(0, 9) == 0) break;   // left open, next start aborts it
            send_item(random_item(KIND_W'($urandom_range(0, 7))));
         end else if (seq_ph == PH_RX_DATA) begin
            send_item(random_item(KIND_RX_BYTE));
         end else begin
            send_item(random_item(KIND_TX_READY));
         end
         guard++;
      end
   endtask

   // events with no transaction open, and the unused kinds
   task automatic test_idle_events();
      send_item(build_item(KIND_TX_READY, '1, '1, '1, '1));
      send_item(build_item(KIND_RX_BYTE, '1, '1, '1, '1));
      send_item(build_item(3'd5, '1, '1, '1, '1));
      send_item(build_item(3'd6, '0, '0, '0, '0));
      send_item(build_item(3'd7, '1, '1, '1, '1));
   endtask

   // two-byte write with extreme values, an rx byte ignored mid-transfer
   task automatic test_short_write();
      send_item(build_item(KIND_LOAD, '0, '0, '0, 8'h00));
      send_item(build_item(KIND_LOAD, '0, '0, '0, 8'hFF));
      send_item(build_item(KIND_START_WRITE, 7'h7F, 8'hFF, 6'd2, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_RX_BYTE, '0, '0, '0, 8'hA5));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
   endtask

   // reads: one byte (stop at restart), zero bytes (acts as a write), three bytes
   task automatic test_reads();
      send_item(build_item(KIND_START_READ, 7'h00, 8'h00, 6'd1, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));   // no action while receiving
      send_item(build_item(KIND_RX_BYTE, '0, '0, '0, 8'hFF));
      send_item(build_item(KIND_START_READ, 7'h55, 8'hAA, 6'd0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_START_READ, 7'h2A, 8'h55, 6'd3, '0));
      finish_transaction(0);
   endtask

   // a start in the middle of a transfer restarts the sequencer
   task automatic test_abort();
      send_item(build_item(KIND_START_READ, 7'h11, 8'h22, 6'd5, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_RX_BYTE, '0, '0, '0, 8'h3C));
      send_item(build_item(KIND_START_WRITE, 7'h33, 8'h44, 6'd1, '0));
      send_item(build_item(KIND_TX_READY, '0, '0, '0, '0));
      send_item(build_item(KIND_START_READ, 7'h66, 8'h77, 6'd2, '0));
      finish_transaction(0);
   endtask

   // fill the store, overflow it by one, then write and read with oversize counts
   task automatic test_store_fill();
      for (int i = 0; i <= BUF_DEPTH; i++)
         send_item(random_item(KIND_LOAD));
      send_item(build_item(KIND_START_WRITE, 7'h5A, 8'hC3, 6'd63, '0));
      finish_transaction(0);
      send_item(build_item(KIND_START_READ, 7'h01, 8'h80, 6'd40, '0));
      finish_transaction(0);
   endtask

   // receiver stalls long enough for the block to fill and stall its input
   task automatic test_backpressure();
      idle_on = 1'b0;
      hold_cycles = 60;
      for (int i = 0; i < 6; i++)
         send_item(random_item(KIND_LOAD));
      send_item(build_item(KIND_START_WRITE, SADDR_W'($urandom), BYTE_W'($urandom), 6'd6, '0));
      finish_transaction(0);
      send_item(build_item(KIND_START_READ, SADDR_W'($urandom), BYTE_W'($urandom), 6'd8, '0));
      finish_transaction(0);
      idle_on = 1'b1;
   endtask

   // random mix of write and read transactions with noise and aborts
   task automatic test_random_traffic();
      int pick, nload;
      while (sent_count < ITEMS_TOTAL) begin
         if (sent_count >= ITEMS_TOTAL - CALM_ITEMS) idle_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            nload = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 34) : $urandom_range(0, 6);
            for (int i = 0; i < nload; i++)
               send_item(random_item(KIND_LOAD));
            send_item(build_item(KIND_START_WRITE, SADDR_W'($urandom), BYTE_W'($urandom),
                                 ($urandom_range(0, 5) == 0) ? REQCNT_W'($urandom)
                                                             : REQCNT_W'($urandom_range(0, nload)),
                                 BYTE_W'($urandom)));
            finish_transaction(8);
         end else if (pick < 80) begin
            send_item(build_item(KIND_START_READ, SADDR_W'($urandom), BYTE_W'($urandom),
                                 ($urandom_range(0, 5) == 0) ? REQCNT_W'($urandom)
                                                             : REQCNT_W'($urandom_range(0, 8)),
                                 BYTE_W'($urandom)));
            finish_transaction(8);
         end else begin
            repeat ($urandom_range(1, 4))
               send_item(random_item(KIND_W'($urandom_range(0, 7))));
         end
      end
   endtask

   // receiver: random stall bursts plus the long hold requested by a test
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // compare each result transaction with the oldest expectation
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with none expected: 0x%0h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("start_tx",    32'(want.start_tx),    32'(rsp_tdata[0]));
            check_field("restart_rx",  32'(want.restart_rx),  32'(rsp_tdata[1]));
            check_field("send_stop",   32'(want.send_stop),   32'(rsp_tdata[2]));
            check_field("tx_valid",    32'(want.tx_valid),    32'(rsp_tdata[3]));
            check_field("tx_byte",     32'(want.tx_byte),     32'(rsp_tdata[11:4]));
            check_field("target_addr", 32'(want.target_addr), 32'(rsp_tdata[18:12]));
            check_field("rx_valid",    32'(want.rx_valid),    32'(rsp_tdata[19]));
            check_field("rx_index",    32'(want.rx_index),    32'(rsp_tdata[24:20]));
            check_field("rx_data",     32'(want.rx_data),     32'(rsp_tdata[32:25]));
            check_field("done_res",    32'(want.done_res),    32'(rsp_tdata[33]));
            check_field("phase",       32'(want.phase),       32'(rsp_tdata[36:34]));
         end
      end
   end

   // watchdog
   initial begin
      #400000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = '0;
      rsp_tready     = 1'b0;
      seq_ph         = PH_IDLE;
      held_reg       = '0;
      held_slave     = '0;
      rx_left        = 0;
      tx_left        = 0;
      rx_pos         = 0;
      tx_pos         = 0;
      load_pos       = 0;
      store_filled   = 0;
      mismatch_count = 0;
      sent_count     = 0;
      idle_on        = 1'b1;
      hold_cycles    = 0;
      stall_left     = 0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      test_idle_events();
      test_short_write();
      test_reads();
      test_abort();
      test_store_fill();
      test_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/i2cs_pkg.sv
rtl/i2cs_wstore.sv
rtl/i2cs_engine.sv
rtl/i2c_master_register_sequencer_top.sv
tb/i2c_master_register_sequencer_top_tb.sv
